>>> rtl/sagm_pkg.sv
// sagm_pkg: shared types and constants for the sparse accumulator block.
// No dependencies; used by the top level and by the port checker.

package sagm_pkg;

  // Default build sizes
  localparam int DEPTH_DEF    = 1024;
  localparam int GEN_BITS_DEF = 8;

  // Fixed field widths
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int SIZE_W  = 11;
  localparam int TOL_W   = 31;
  localparam int COUNT_W = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  // Width used for index/size compares (holds DEPTH up to 65536)
  localparam int CMP_W   = 17;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_GET   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PACK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd5;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Register select (paddr bit 2)
  localparam logic REG_ACTIVE_SIZE = 1'b0;
  localparam logic REG_PACK_TOL    = 1'b1;

  localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

  // Q16.16 saturation limits
  localparam logic [VAL_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] S32_MIN = 32'h8000_0000;

endpackage

>>> rtl/sparse_accumulator_generation_marks.sv
// sparse_accumulator_generation_marks: sparse accumulator with generation marks.
// Depends on sagm_pkg (widths, request codes, register selects).
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+------------------------------------------
//   request   | in_valid / in_ready          | req_type, index, value
//   result    | out_valid / out_ready        | status, value_out, index_out, entry_count
//   registers | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Each request is accepted in IDLE, which reads the entry memory and the list memory,
// and then moves to EXEC to modify and write back; no new request is taken until that
// read-modify-write is done, which sets the rate.
// After reset, and after a clear that wraps the generation counter, a wipe pass
// zeroes every mark, one entry per cycle, with in_ready low.
// A result waits in the output register; the next request is taken meanwhile,
// and its write-back stalls only while the previous result is still untaken.

module sparse_accumulator_generation_marks #(
  parameter int DEPTH    = sagm_pkg::DEPTH_DEF,
  parameter int GEN_BITS = sagm_pkg::GEN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sagm_pkg::REQ_W-1:0]        req_type,
  input  logic [sagm_pkg::IDX_W-1:0]        index,
  input  logic signed [sagm_pkg::VAL_W-1:0] value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic signed [sagm_pkg::VAL_W-1:0] value_out,
  output logic [sagm_pkg::IDX_W-1:0]        index_out,
  output logic [sagm_pkg::COUNT_W-1:0]      entry_count,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sagm_pkg::PADDR_W-1:0]      paddr,
  input  logic [sagm_pkg::PDATA_W-1:0]      pwdata,
  output logic [sagm_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // entry / slot address
  localparam int CW   = AW + 1;                           // list count, holds DEPTH
  localparam int VW   = sagm_pkg::VAL_W;
  localparam int IW   = sagm_pkg::IDX_W;
  localparam int EW   = GEN_BITS + AW + VW;               // entry word: mark, slot, value
  localparam int LWD  = IW + VW;                          // list word: index, value
  localparam int XW   = sagm_pkg::CMP_W;

  localparam logic [XW-1:0] DEPTH_X   = XW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

  // sequencer
  localparam logic [1:0] ST_WIPE = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state;
  logic [AW-1:0] wipe_cnt;

  // configuration registers
  logic [sagm_pkg::SIZE_W-1:0] active_size;
  logic [sagm_pkg::TOL_W-1:0]  pack_tolerance;

  // scalar state
  logic [GEN_BITS-1:0] gen;
  logic [CW-1:0]       list_count;

  // latched request
  logic [sagm_pkg::REQ_W-1:0] req_q;
  logic [IW-1:0]              idx_q;
  logic [VW-1:0]              val_q;

  // memories
  logic [EW-1:0]  ent_mem [DEPTH];
  logic [LWD-1:0] list_mem [DEPTH];
  logic [EW-1:0]  ent_rdata;
  logic [LWD-1:0] list_rdata;

  logic           ent_we;
  logic [AW-1:0]  ent_waddr;
  logic [EW-1:0]  ent_wdata;
  logic           list_we;
  logic [AW-1:0]  list_waddr;
  logic [LWD-1:0] list_wdata;
  logic           rd_en;

  // ---------------------------------------------------------------------------
  // Register port: zero wait states.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      sagm_pkg::REG_ACTIVE_SIZE: prdata = sagm_pkg::PDATA_W'(active_size);
      sagm_pkg::REG_PACK_TOL:    prdata = sagm_pkg::PDATA_W'(pack_tolerance);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size    <= sagm_pkg::ACTIVE_SIZE_RST;
      pack_tolerance <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        sagm_pkg::REG_ACTIVE_SIZE: active_size    <= pwdata[sagm_pkg::SIZE_W-1:0];
        sagm_pkg::REG_PACK_TOL:    pack_tolerance <= pwdata[sagm_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request accept. Both memories are read at the request's address; the data
  // comes back registered for the execute cycle.
  // ---------------------------------------------------------------------------
  assign in_ready = (state == ST_IDLE);
  assign rd_en    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      req_q <= req_type;
      idx_q <= index;
      val_q <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (rd_en)  ent_rdata <= ent_mem[AW'(index)];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    if (rd_en)   list_rdata <= list_mem[AW'(index)];
  end

  // ---------------------------------------------------------------------------
  // Execute: decode the entry read back, work out the new value and result.
  // The write-back lands before the next request can issue its read, so the
  // same entry never sees overlapping accesses.
  // ---------------------------------------------------------------------------
  logic [GEN_BITS-1:0] rd_mark;
  logic [AW-1:0]       rd_slot;
  logic [VW-1:0]       rd_val;
  logic [XW-1:0]       limit;
  logic                in_range;
  logic                present;
  logic [VW:0]         sum;
  logic [VW-1:0]       sat_sum;
  logic [VW-1:0]       mag;
  logic                above_tol;
  logic                slot_ok;
  logic                exec_go;
  logic                do_write;
  logic [VW-1:0]       new_val;
  logic                res_status;
  logic [VW-1:0]       res_value;
  logic [IW-1:0]       res_index;
  logic                insert;

  assign rd_mark = ent_rdata[EW-1 -: GEN_BITS];
  assign rd_slot = ent_rdata[VW +: AW];
  assign rd_val  = ent_rdata[VW-1:0];

  assign limit    = (XW'(active_size) < DEPTH_X) ? XW'(active_size) : DEPTH_X;
  assign in_range = XW'(idx_q) < limit;
  assign present  = in_range && (rd_mark == gen);

  // saturating Q16.16 add
  assign sum = {rd_val[VW-1], rd_val} + {val_q[VW-1], val_q};
  always_comb begin
    if (sum[VW] != sum[VW-1]) sat_sum = sum[VW] ? sagm_pkg::S32_MIN : sagm_pkg::S32_MAX;
    else                      sat_sum = sum[VW-1:0];
  end

  // |value|; the most negative code gives 2^31 as unsigned
  assign mag       = val_q[VW-1] ? (~val_q + 1'b1) : val_q;
  assign above_tol = mag > VW'(pack_tolerance);

  assign slot_ok = (XW'(idx_q) < XW'(list_count)) && (XW'(idx_q) < DEPTH_X);

  // result register must be free (or emptying) before write-back
  assign exec_go = (state == ST_EXEC) && (!out_valid || out_ready);

  always_comb begin
    do_write   = 1'b0;
    new_val    = val_q;
    res_status = sagm_pkg::STATUS_OK;
    res_value  = '0;
    res_index  = '0;
    case (req_q)
      sagm_pkg::REQ_CLEAR: ;
      sagm_pkg::REQ_SET: begin
        if (!in_range) res_status = sagm_pkg::STATUS_RANGE;
        else           do_write   = present || (val_q != '0);
      end
      sagm_pkg::REQ_ADD: begin
        if (!in_range) begin
          res_status = sagm_pkg::STATUS_RANGE;
        end else if (present) begin
          do_write = 1'b1;
          new_val  = sat_sum;
        end else begin
          do_write = (val_q != '0);
        end
      end
      sagm_pkg::REQ_GET: begin
        if (!in_range)    res_status = sagm_pkg::STATUS_RANGE;
        else if (present) res_value  = rd_val;
      end
      sagm_pkg::REQ_PACK: begin
        if (!in_range) res_status = sagm_pkg::STATUS_RANGE;
        else           do_write   = above_tol;
      end
      sagm_pkg::REQ_READ: begin
        if (slot_ok) begin
          res_value = list_rdata[VW-1:0];
          res_index = list_rdata[LWD-1 -: IW];
        end else begin
          res_status = sagm_pkg::STATUS_RANGE;
        end
      end
      default: ;
    endcase
  end

  // an absent entry is appended unless the list is full
  assign insert = do_write && !present && (list_count < DEPTH_C);

  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = AW'(idx_q);
    ent_wdata  = {gen, rd_slot, new_val};
    list_we    = 1'b0;
    list_waddr = rd_slot;
    list_wdata = {idx_q, new_val};
    if (state == ST_WIPE) begin
      ent_we    = 1'b1;
      ent_waddr = wipe_cnt;
      ent_wdata = '0;
    end else if (exec_go && do_write) begin
      if (present) begin
        ent_we  = 1'b1;
        list_we = 1'b1;
      end else if (insert) begin
        ent_we     = 1'b1;
        list_we    = 1'b1;
        ent_wdata  = {gen, list_count[AW-1:0], new_val};
        list_waddr = list_count[AW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, generation, list count and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WIPE;
      wipe_cnt   <= '0;
      gen        <= GEN_BITS'(1);
      list_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // a new result loads the register, else a taken one empties it
      if (exec_go)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_WIPE: begin
          wipe_cnt <= wipe_cnt + 1'b1;
          if (wipe_cnt == LAST_ADDR) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (rd_en) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_go) begin
            if (req_q == sagm_pkg::REQ_CLEAR) begin
              list_count <= '0;
              if (&gen) begin
                // wrap: old marks could alias, sweep them away
                gen      <= GEN_BITS'(1);
                wipe_cnt <= '0;
                state    <= ST_WIPE;
              end else begin
                gen   <= gen + 1'b1;
                state <= ST_IDLE;
              end
            end else begin
              state <= ST_IDLE;
              if (insert) list_count <= list_count + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status    <= res_status;
      value_out <= res_value;
      index_out <= res_index;
      if (req_q == sagm_pkg::REQ_CLEAR)
        entry_count <= '0;
      else
        entry_count <= sagm_pkg::COUNT_W'(list_count + CW'(insert));
    end
  end

endmodule

>>> rtl/sagm_checker.sv
// sagm_props: port-level assertions for the sparse accumulator.
// Depends on sagm_pkg; bound to sparse_accumulator_generation_marks below.

module sagm_props (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              status,
  input logic signed [sagm_pkg::VAL_W-1:0] value_out,
  input logic [sagm_pkg::IDX_W-1:0]        index_out,
  input logic [sagm_pkg::COUNT_W-1:0]      entry_count
);

  // one request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still executing");

  // a rejected request carries zero data
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sagm_pkg::STATUS_RANGE) |-> (value_out == '0 && index_out == '0))
    else $error("out-of-range result carries nonzero data");

  // entry count on a result never exceeds 1024, the default vector size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= sagm_pkg::COUNT_W'(1024)))
    else $error("entry count above vector size");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value_out) && $stable(entry_count)))
    else $error("result changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sparse_accumulator_generation_marks sagm_props u_sagm_checker (.*);
